[design/hkae_pkg.sv]
// ----------------------------------------------------------------------------
// hkae_pkg: shared types and constants
// Event record, HID usage to ADB key code table, modifier key codes.
// ----------------------------------------------------------------------------
package hkae_pkg;

  localparam int KEY_W       = 8;
  localparam int ADB_W       = 7;
  localparam int INPUT_SLOTS = 6;
  localparam int MOD_BITS    = 8;
  localparam int MOD_PAIRS   = 4;
  localparam int MAX_EVENTS  = 16;
  localparam int EVT_CNT_W   = 4;

  localparam logic [KEY_W-1:0] NO_CODE = 8'hFF;
  localparam logic [KEY_W-1:0] NO_KEY  = 8'h00;

  // request kinds carried in req_type
  typedef enum logic {REQ_REPORT = 1'b0, REQ_DISCONNECT = 1'b1} req_kind_t;

  // one candidate event from a lane
  typedef struct packed {
    logic             vld;
    logic [ADB_W-1:0] code;
    logic             down;
  } key_evt_t;

  // ADB codes for Ctrl, Shift, Alt/Option, Gui/Command
  function automatic logic [ADB_W-1:0] mod_code(input logic [1:0] pair);
    logic [ADB_W-1:0] c;
    unique case (pair)
      2'd0: c = 7'h36;
      2'd1: c = 7'h38;
      2'd2: c = 7'h3A;
      2'd3: c = 7'h37;
    endcase
    return c;
  endfunction

  function automatic logic [KEY_W-1:0] adb_rom(input logic [KEY_W-1:0] usage);
    logic [KEY_W-1:0] c;
    unique case (usage)
      8'd4:   c = 8'h00;  8'd5:   c = 8'h0B;  8'd6:   c = 8'h08;  8'd7:   c = 8'h02;
      8'd8:   c = 8'h0E;  8'd9:   c = 8'h03;  8'd10:  c = 8'h05;  8'd11:  c = 8'h04;
      8'd12:  c = 8'h22;  8'd13:  c = 8'h26;  8'd14:  c = 8'h28;  8'd15:  c = 8'h25;
      8'd16:  c = 8'h2E;  8'd17:  c = 8'h2D;  8'd18:  c = 8'h1F;  8'd19:  c = 8'h23;
      8'd20:  c = 8'h0C;  8'd21:  c = 8'h0F;  8'd22:  c = 8'h01;  8'd23:  c = 8'h11;
      8'd24:  c = 8'h20;  8'd25:  c = 8'h09;  8'd26:  c = 8'h0D;  8'd27:  c = 8'h07;
      8'd28:  c = 8'h10;  8'd29:  c = 8'h06;
      8'd30:  c = 8'h12;  8'd31:  c = 8'h13;  8'd32:  c = 8'h14;  8'd33:  c = 8'h15;
      8'd34:  c = 8'h17;  8'd35:  c = 8'h16;  8'd36:  c = 8'h1A;  8'd37:  c = 8'h1C;
      8'd38:  c = 8'h19;  8'd39:  c = 8'h1D;
      8'd40:  c = 8'h24;  8'd41:  c = 8'h35;  8'd42:  c = 8'h33;  8'd43:  c = 8'h30;
      8'd44:  c = 8'h31;
      8'd45:  c = 8'h1B;  8'd46:  c = 8'h18;  8'd47:  c = 8'h21;  8'd48:  c = 8'h1E;
      8'd49:  c = 8'h2A;  8'd50:  c = 8'h32;  8'd51:  c = 8'h29;  8'd52:  c = 8'h27;
      8'd53:  c = 8'h0A;  8'd54:  c = 8'h2B;  8'd55:  c = 8'h2F;  8'd56:  c = 8'h2C;
      8'd57:  c = 8'h39;
      8'd58:  c = 8'h7A;  8'd59:  c = 8'h78;  8'd60:  c = 8'h63;  8'd61:  c = 8'h76;
      8'd62:  c = 8'h60;  8'd63:  c = 8'h61;  8'd64:  c = 8'h62;  8'd65:  c = 8'h64;
      8'd66:  c = 8'h65;  8'd67:  c = 8'h6D;  8'd68:  c = 8'h67;  8'd69:  c = 8'h6F;
      8'd70:  c = 8'h69;  8'd71:  c = 8'h6B;  8'd72:  c = 8'h71;
      8'd73:  c = 8'h72;  8'd74:  c = 8'h73;  8'd75:  c = 8'h74;  8'd76:  c = 8'h75;
      8'd77:  c = 8'h77;  8'd78:  c = 8'h79;
      8'd79:  c = 8'h3C;  8'd80:  c = 8'h3B;  8'd81:  c = 8'h3D;  8'd82:  c = 8'h3E;
      8'd83:  c = 8'h47;
      8'd84:  c = 8'h4B;  8'd85:  c = 8'h43;  8'd86:  c = 8'h4E;  8'd87:  c = 8'h45;
      8'd88:  c = 8'h4C;  8'd89:  c = 8'h53;  8'd90:  c = 8'h54;  8'd91:  c = 8'h55;
      8'd92:  c = 8'h56;  8'd93:  c = 8'h57;  8'd94:  c = 8'h58;  8'd95:  c = 8'h59;
      8'd96:  c = 8'h5B;  8'd97:  c = 8'h5C;  8'd98:  c = 8'h52;  8'd99:  c = 8'h41;
      8'd100: c = 8'h32;  8'd101: c = 8'h32;  8'd102: c = 8'h7F;  8'd103: c = 8'h51;
      8'd104: c = 8'h69;  8'd105: c = 8'h6B;  8'd106: c = 8'h71;
      // modifier usages, left then right
      8'd224: c = 8'h36;  8'd225: c = 8'h38;  8'd226: c = 8'h3A;  8'd227: c = 8'h37;
      8'd228: c = 8'h36;  8'd229: c = 8'h38;  8'd230: c = 8'h3A;  8'd231: c = 8'h37;
      default: c = NO_CODE;
    endcase
    return c;
  endfunction

endpackage

[design/hkae_in_if.sv]
// ----------------------------------------------------------------------------
// hkae_in_if: keyboard report channel
// valid/ready handshake carrying one report or disconnect request.
// ----------------------------------------------------------------------------
interface hkae_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] modifier_bits;
  logic [7:0] key_slot_0;
  logic [7:0] key_slot_1;
  logic [7:0] key_slot_2;
  logic [7:0] key_slot_3;
  logic [7:0] key_slot_4;
  logic [7:0] key_slot_5;

  modport source (
    output valid, req_type, modifier_bits,
    output key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
    input  ready
  );
  modport sink (
    input  valid, req_type, modifier_bits,
    input  key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
    output ready
  );
endinterface

[design/hkae_out_if.sv]
// ----------------------------------------------------------------------------
// hkae_out_if: ADB key event channel
// valid/ready handshake carrying one key event.
// ----------------------------------------------------------------------------
interface hkae_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] adb_keycode;
  logic       key_down;
  logic       last_event;

  modport source (output valid, adb_keycode, key_down, last_event, input ready);
  modport sink   (input valid, adb_keycode, key_down, last_event, output ready);
endinterface

[design/hkae_mod_lane.sv]
// ----------------------------------------------------------------------------
// hkae_mod_lane: one left/right modifier pair
// Gives the left and right side events with the two sides merged.
// ----------------------------------------------------------------------------
module hkae_mod_lane (
  input  logic                    en,
  input  logic [1:0]              pair,
  input  logic                    old_l,
  input  logic                    old_r,
  input  logic                    new_l,
  input  logic                    new_r,
  output hkae_pkg::key_evt_t      left_ev,
  output hkae_pkg::key_evt_t      right_ev
);

  logic [hkae_pkg::ADB_W-1:0] code;

  assign code = hkae_pkg::mod_code(pair);

  // left side is handled first, so it sees the old right side
  assign left_ev.vld  = en & (new_l ^ old_l) & ~old_r;
  assign left_ev.code = code;
  assign left_ev.down = new_l;

  // right side sees the already updated left side
  assign right_ev.vld  = en & (new_r ^ old_r) & ~new_l;
  assign right_ev.code = code;
  assign right_ev.down = new_r;

endmodule

[design/hkae_key_lane.sv]
// ----------------------------------------------------------------------------
// hkae_key_lane: one key slot
// Release candidate for the old key, press candidate for the new key.
// ----------------------------------------------------------------------------
module hkae_key_lane #(
  parameter int KEY_SLOTS = 6
) (
  input  logic                                    en,
  input  logic [hkae_pkg::KEY_W-1:0]              old_key,
  input  logic [hkae_pkg::KEY_W-1:0]              new_key,
  input  logic [KEY_SLOTS-1:0][hkae_pkg::KEY_W-1:0] old_set,
  input  logic [KEY_SLOTS-1:0][hkae_pkg::KEY_W-1:0] new_set,
  output hkae_pkg::key_evt_t                      rel_ev,
  output hkae_pkg::key_evt_t                      prs_ev
);

  logic [KEY_SLOTS-1:0]         old_hit;
  logic [KEY_SLOTS-1:0]         new_hit;
  logic [hkae_pkg::KEY_W-1:0]   old_adb;
  logic [hkae_pkg::KEY_W-1:0]   new_adb;

  always_comb begin
    for (int j = 0; j < KEY_SLOTS; j++) begin
      old_hit[j] = (new_set[j] == old_key);
      new_hit[j] = (old_set[j] == new_key);
    end
  end

  assign old_adb = hkae_pkg::adb_rom(old_key);
  assign new_adb = hkae_pkg::adb_rom(new_key);

  assign rel_ev.vld  = en && (old_key != hkae_pkg::NO_KEY) && !(|old_hit)
                       && (old_adb != hkae_pkg::NO_CODE);
  assign rel_ev.code = old_adb[hkae_pkg::ADB_W-1:0];
  assign rel_ev.down = 1'b0;

  assign prs_ev.vld  = en && (new_key != hkae_pkg::NO_KEY) && !(|new_hit)
                       && (new_adb != hkae_pkg::NO_CODE);
  assign prs_ev.code = new_adb[hkae_pkg::ADB_W-1:0];
  assign prs_ev.down = 1'b1;

endmodule

[design/hkae_merge.sv]
// ----------------------------------------------------------------------------
// hkae_merge: event serializer
// Holds one request's candidates and sends them out in order, at most 16.
// ----------------------------------------------------------------------------
module hkae_merge #(
  parameter int EVT_SLOTS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cand_valid,
  output logic                               cand_ready,
  input  hkae_pkg::key_evt_t [EVT_SLOTS-1:0] cand,
  hkae_out_if.source                         out_evt
);

  logic [EVT_SLOTS-1:0]                   vld_r, vld_nxt;
  hkae_pkg::key_evt_t [EVT_SLOTS-1:0]     evs_r;
  logic                                   busy_r, busy_nxt;
  logic [hkae_pkg::EVT_CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                                   out_vld_r, out_vld_nxt;
  logic [hkae_pkg::ADB_W-1:0]             code_r;
  logic                                   down_r;
  logic                                   last_r;

  logic [EVT_SLOTS-1:0]                   cand_vld;
  logic                                   cand_any;
  logic [EVT_SLOTS-1:0]                   first_oh;
  logic [EVT_SLOTS-1:0]                   remain;
  logic [hkae_pkg::ADB_W-1:0]             pick_code;
  logic                                   pick_down;
  logic                                   pick_last;
  logic                                   step;
  logic                                   load;

  always_comb begin
    for (int i = 0; i < EVT_SLOTS; i++) cand_vld[i] = cand[i].vld;
  end
  assign cand_any = |cand_vld;

  // lowest pending position goes first
  always_comb begin
    logic seen;
    seen      = 1'b0;
    pick_code = '0;
    pick_down = 1'b0;
    for (int i = 0; i < EVT_SLOTS; i++) begin
      first_oh[i] = vld_r[i] & ~seen;
      seen        = seen | vld_r[i];
      pick_code   = pick_code | (evs_r[i].code & {hkae_pkg::ADB_W{first_oh[i]}});
      pick_down   = pick_down | (evs_r[i].down & first_oh[i]);
    end
  end

  assign remain    = vld_r & ~first_oh;
  assign pick_last = (remain == '0)
                     || (cnt_r == hkae_pkg::EVT_CNT_W'(hkae_pkg::MAX_EVENTS - 1));
  assign step      = busy_r && (!out_vld_r || out_evt.ready);
  assign cand_ready = !cand_any || !busy_r || (step && pick_last);
  assign load      = cand_valid && cand_ready && cand_any;

  always_comb begin
    vld_nxt  = vld_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (step) begin
      vld_nxt = remain;
      cnt_nxt = cnt_r + 1'b1;
      if (pick_last) busy_nxt = 1'b0;
    end
    if (load) begin
      vld_nxt  = cand_vld;
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end
    if (step) out_vld_nxt = 1'b1;
    else if (out_evt.ready) out_vld_nxt = 1'b0;
    else out_vld_nxt = out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      busy_r    <= 1'b0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      busy_r    <= busy_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) evs_r <= cand;
    if (step) begin
      code_r <= pick_code;
      down_r <= pick_down;
      last_r <= pick_last;
    end
  end

  assign out_evt.valid       = out_vld_r;
  assign out_evt.adb_keycode = code_r;
  assign out_evt.key_down    = down_r;
  assign out_evt.last_event  = last_r;

endmodule

[design/hid_keyboard_to_adb_key_events_unit.sv]
// ----------------------------------------------------------------------------
// hid_keyboard_to_adb_key_events_unit: HID boot keyboard to ADB key events
// Modifier and key slot lanes find candidate events, a serializer sends them.
// ----------------------------------------------------------------------------
// A request is registered, loaded into the serializer, and each event registered.
// Throughput: one event per cycle unless the output stalls; a request holds the
// serializer until its events (at most 16) are sent, one without events skips
// it. The next request is taken while the current one is still being sent.
// Reset: modifier and previous key state cleared, key_enable set to 1.
module hid_keyboard_to_adb_key_events_unit #(
  parameter int KEY_SLOTS = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  hkae_in_if.sink    in_req,
  hkae_out_if.source out_evt
);

  localparam int EVT_SLOTS = hkae_pkg::MOD_BITS + 2 * KEY_SLOTS;
  localparam int KW        = hkae_pkg::KEY_W;

  logic                            key_en_r;
  logic [7:0]                      side_mods_r;
  logic [KEY_SLOTS-1:0][KW-1:0]    prev_keys_r;

  logic                            s0_vld_r, s0_vld_nxt;
  logic                            s0_en_r;
  logic [7:0]                      s0_old_mods_r;
  logic [7:0]                      s0_new_mods_r;
  logic [KEY_SLOTS-1:0][KW-1:0]    s0_old_r;
  logic [KEY_SLOTS-1:0][KW-1:0]    s0_new_r;

  logic [hkae_pkg::INPUT_SLOTS-1:0][KW-1:0] in_slots;
  logic [KEY_SLOTS-1:0][KW-1:0]    now_keys;
  logic                            in_acc;
  logic                            cand_ready;
  hkae_pkg::key_evt_t [EVT_SLOTS-1:0] cand;

  assign in_slots = {in_req.key_slot_5, in_req.key_slot_4, in_req.key_slot_3,
                     in_req.key_slot_2, in_req.key_slot_1, in_req.key_slot_0};

  // slots past the input fields read as empty
  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_now
    if (i < hkae_pkg::INPUT_SLOTS) begin : g_in
      assign now_keys[i] = in_slots[i];
    end else begin : g_empty
      assign now_keys[i] = hkae_pkg::NO_KEY;
    end
  end

  assign in_req.ready = !s0_vld_r || cand_ready;
  assign in_acc       = in_req.valid && in_req.ready;

  always_comb begin
    if (in_acc) s0_vld_nxt = 1'b1;
    else if (cand_ready) s0_vld_nxt = 1'b0;
    else s0_vld_nxt = s0_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_en_r    <= 1'b1;
      side_mods_r <= '0;
      prev_keys_r <= '0;
      s0_vld_r    <= 1'b0;
    end else begin
      s0_vld_r <= s0_vld_nxt;
      if (cfg_wr_en) key_en_r <= cfg_wr_data;
      if (in_acc) begin
        if (in_req.req_type == hkae_pkg::REQ_DISCONNECT) begin
          side_mods_r <= '0;
          prev_keys_r <= '0;
        end else begin
          prev_keys_r <= now_keys;
          if (key_en_r) side_mods_r <= in_req.modifier_bits;
        end
      end
    end
  end

  // snapshot of the request together with the state it found
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_en_r       <= key_en_r & (in_req.req_type == hkae_pkg::REQ_REPORT);
      s0_old_mods_r <= side_mods_r;
      s0_new_mods_r <= in_req.modifier_bits;
      s0_old_r      <= prev_keys_r;
      s0_new_r      <= now_keys;
    end
  end

  for (genvar p = 0; p < hkae_pkg::MOD_PAIRS; p++) begin : g_mod
    hkae_mod_lane u_mod (
      .en       (s0_en_r),
      .pair     (2'(p)),
      .old_l    (s0_old_mods_r[p]),
      .old_r    (s0_old_mods_r[p + hkae_pkg::MOD_PAIRS]),
      .new_l    (s0_new_mods_r[p]),
      .new_r    (s0_new_mods_r[p + hkae_pkg::MOD_PAIRS]),
      .left_ev  (cand[p]),
      .right_ev (cand[p + hkae_pkg::MOD_PAIRS])
    );
  end

  // releases follow the modifiers, presses follow the releases
  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_key
    hkae_key_lane #(.KEY_SLOTS(KEY_SLOTS)) u_key (
      .en      (s0_en_r),
      .old_key (s0_old_r[i]),
      .new_key (s0_new_r[i]),
      .old_set (s0_old_r),
      .new_set (s0_new_r),
      .rel_ev  (cand[hkae_pkg::MOD_BITS + i]),
      .prs_ev  (cand[hkae_pkg::MOD_BITS + KEY_SLOTS + i])
    );
  end

  hkae_merge #(.EVT_SLOTS(EVT_SLOTS)) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .cand_valid (s0_vld_r),
    .cand_ready (cand_ready),
    .cand       (cand),
    .out_evt    (out_evt)
  );

endmodule
